// ----- sv/acpi_rtp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpi_rtp_pkg
// Shared types and codes of the resource template parser: descriptor tags,
// record kinds, trigger types and the record carried to the output buffer.
// ----------------------------------------------------------------------------
package acpi_rtp_pkg;

  localparam logic [7:0] TAG_SERIAL_BUS = 8'h8E;
  localparam logic [7:0] TAG_GPIO       = 8'h8C;
  localparam logic [3:0] NAME_END_TAG   = 4'hF;
  localparam logic [7:0] BUS_TYPE_I2C   = 8'h01;
  localparam logic [7:0] GPIO_KIND_INT  = 8'h00;
  localparam logic [7:0] GPIO_KIND_IO   = 8'h01;
  localparam logic [15:0] PIN_NONE      = 16'hFFFF;

  localparam logic [16:0] I2C_MIN_LEN  = 17'd18;
  localparam logic [16:0] GPIO_MIN_LEN = 17'd16;
  localparam logic [16:0] LARGE_HDR    = 17'd3;

  localparam logic [1:0] KIND_I2C      = 2'd0;
  localparam logic [1:0] KIND_GPIO_INT = 2'd1;
  localparam logic [1:0] KIND_GPIO_IO  = 2'd2;

  localparam logic [2:0] TRIG_LEVEL_HIGH   = 3'd0;
  localparam logic [2:0] TRIG_LEVEL_LOW    = 3'd1;
  localparam logic [2:0] TRIG_EDGE_FALLING = 3'd2;
  localparam logic [2:0] TRIG_EDGE_RISING  = 3'd3;
  localparam logic [2:0] TRIG_EDGE_BOTH    = 3'd4;

  localparam logic [1:0] POL_HIGH = 2'd0;
  localparam logic [1:0] POL_BOTH = 2'd2;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic        consumer;
    logic        dev_init;
    logic        ten_bit_address;
    logic [31:0] link_hz;
    logic [15:0] target;
    logic [2:0]  trigger_type;
    logic [1:0]  polarity;
    logic        shared;
    logic        wake;
    logic [1:0]  io_limit;
    logic [7:0]  pad_cfg;
  } record_t;

endpackage

// ----- sv/acpi_rtp_walker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpi_rtp_walker
// Descriptor walker: tracks position and length, captures the I2C and GPIO
// fields and builds a record at the last byte of a reportable descriptor.
// ----------------------------------------------------------------------------
module acpi_rtp_walker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output logic                  rec_valid,
  output acpi_rtp_pkg::record_t rec
);

  logic [16:0] byte_position, byte_position_next;
  logic [16:0] descriptor_length, descriptor_length_next;
  logic [7:0]  descriptor_tag, descriptor_tag_next;
  logic [7:0]  bus_type, bus_type_next;
  logic [7:0]  flags_byte, flags_byte_next;
  logic [7:0]  type_flags, type_flags_next;
  logic [31:0] speed_capture, speed_capture_next;
  logic [15:0] address_capture, address_capture_next;
  logic [7:0]  gpio_kind, gpio_kind_next;
  logic [7:0]  pad_cfg_capture, pad_cfg_capture_next;
  logic [15:0] pin_table_offset, pin_table_offset_next;
  logic [15:0] pin_capture, pin_capture_next;
  logic        pin_seen, pin_seen_next;
  logic        i2c_found, i2c_found_next;
  logic        interrupt_found, interrupt_found_next;
  logic        parse_done, parse_done_next;

  logic        long_item;
  logic        ends;
  logic        emit;
  logic [1:0]  pol;
  logic [2:0]  trig;
  acpi_rtp_pkg::record_t rec_c;

  assign long_item = descriptor_tag[7];
  assign pol       = type_flags_next[2:1];

  always_comb begin
    if (!type_flags_next[0]) begin
      trig = (pol == acpi_rtp_pkg::POL_HIGH) ? acpi_rtp_pkg::TRIG_LEVEL_HIGH
                                             : acpi_rtp_pkg::TRIG_LEVEL_LOW;
    end else if (pol == acpi_rtp_pkg::POL_HIGH) begin
      trig = acpi_rtp_pkg::TRIG_EDGE_RISING;
    end else if (pol == acpi_rtp_pkg::POL_BOTH) begin
      trig = acpi_rtp_pkg::TRIG_EDGE_BOTH;
    end else begin
      trig = acpi_rtp_pkg::TRIG_EDGE_FALLING;
    end
  end

  always_comb begin
    byte_position_next      = byte_position;
    descriptor_length_next  = descriptor_length;
    descriptor_tag_next     = descriptor_tag;
    bus_type_next           = bus_type;
    flags_byte_next         = flags_byte;
    type_flags_next         = type_flags;
    speed_capture_next      = speed_capture;
    address_capture_next    = address_capture;
    gpio_kind_next          = gpio_kind;
    pad_cfg_capture_next    = pad_cfg_capture;
    pin_table_offset_next   = pin_table_offset;
    pin_capture_next        = pin_capture;
    pin_seen_next           = pin_seen;
    parse_done_next         = parse_done;
    ends                    = 1'b0;

    if (!parse_done) begin
      if (byte_position == 17'd0) begin
        descriptor_tag_next     = data_byte;
        bus_type_next           = '0;
        flags_byte_next         = '0;
        type_flags_next         = '0;
        speed_capture_next      = '0;
        address_capture_next    = '0;
        gpio_kind_next          = '0;
        pad_cfg_capture_next    = '0;
        pin_table_offset_next   = '0;
        pin_capture_next        = '0;
        pin_seen_next           = 1'b0;
        if (data_byte[7]) begin
          descriptor_length_next = '0;
          byte_position_next     = 17'd1;
        end else if (data_byte[6:3] == acpi_rtp_pkg::NAME_END_TAG) begin
          parse_done_next = 1'b1;
        end else begin
          descriptor_length_next = {14'd0, data_byte[2:0]} + 17'd1;
          byte_position_next     = (data_byte[2:0] == 3'd0) ? 17'd0 : 17'd1;
        end
      end else begin
        if (long_item && byte_position == 17'd1) begin
          descriptor_length_next = {9'd0, data_byte};
        end else if (long_item && byte_position == 17'd2) begin
          descriptor_length_next = {1'b0, data_byte, descriptor_length[7:0]}
                                   + acpi_rtp_pkg::LARGE_HDR;
        end

        if (descriptor_tag == acpi_rtp_pkg::TAG_SERIAL_BUS) begin
          case (byte_position)
            17'd5:   bus_type_next = data_byte;
            17'd6:   flags_byte_next = data_byte;
            17'd7:   type_flags_next = data_byte;
            17'd12:  speed_capture_next[7:0] = data_byte;
            17'd13:  speed_capture_next[15:8] = data_byte;
            17'd14:  speed_capture_next[23:16] = data_byte;
            17'd15:  speed_capture_next[31:24] = data_byte;
            17'd16:  address_capture_next[7:0] = data_byte;
            17'd17:  address_capture_next[15:8] = data_byte;
            default: ;
          endcase
        end else if (descriptor_tag == acpi_rtp_pkg::TAG_GPIO) begin
          case (byte_position)
            17'd4:   gpio_kind_next = data_byte;
            17'd5:   flags_byte_next = data_byte;
            17'd7:   type_flags_next = data_byte;
            17'd9:   pad_cfg_capture_next = data_byte;
            17'd14:  pin_table_offset_next[7:0] = data_byte;
            17'd15:  pin_table_offset_next[15:8] = data_byte;
            default: begin
              if (byte_position >= 17'd16) begin
                if (byte_position == {1'b0, pin_table_offset}) begin
                  pin_capture_next[7:0] = data_byte;
                end else if (byte_position == {1'b0, pin_table_offset} + 17'd1) begin
                  pin_capture_next[15:8] = data_byte;
                  pin_seen_next          = 1'b1;
                end
              end
            end
          endcase
        end

        ends = (!long_item || byte_position >= 17'd2) &&
               ({1'b0, byte_position} + 18'd1 >= {1'b0, descriptor_length_next});
        byte_position_next = ends ? 17'd0 : byte_position + 17'd1;
      end
    end
  end

  always_comb begin
    rec_c                = '0;
    emit                 = 1'b0;
    i2c_found_next       = i2c_found;
    interrupt_found_next = interrupt_found;
    if (ends && long_item) begin
      if (descriptor_tag == acpi_rtp_pkg::TAG_SERIAL_BUS) begin
        if (!i2c_found && bus_type_next == acpi_rtp_pkg::BUS_TYPE_I2C &&
            descriptor_length_next >= acpi_rtp_pkg::I2C_MIN_LEN) begin
          emit                  = 1'b1;
          i2c_found_next        = 1'b1;
          rec_c.record_kind     = acpi_rtp_pkg::KIND_I2C;
          rec_c.consumer        = flags_byte_next[1];
          rec_c.dev_init        = flags_byte_next[0];
          rec_c.ten_bit_address = type_flags_next[0];
          rec_c.link_hz         = speed_capture_next;
          rec_c.target          = address_capture_next;
        end
      end else if (descriptor_tag == acpi_rtp_pkg::TAG_GPIO) begin
        if (!interrupt_found && descriptor_length_next >= acpi_rtp_pkg::GPIO_MIN_LEN &&
            pin_seen_next && pin_capture_next != acpi_rtp_pkg::PIN_NONE) begin
          rec_c.consumer = flags_byte_next[0];
          rec_c.target   = pin_capture_next;
          rec_c.shared   = type_flags_next[3];
          rec_c.pad_cfg  = pad_cfg_capture_next;
          if (gpio_kind_next == acpi_rtp_pkg::GPIO_KIND_INT) begin
            emit                 = 1'b1;
            interrupt_found_next = 1'b1;
            rec_c.record_kind    = acpi_rtp_pkg::KIND_GPIO_INT;
            rec_c.trigger_type   = trig;
            rec_c.polarity       = pol;
            rec_c.wake           = type_flags_next[4];
          end else if (gpio_kind_next == acpi_rtp_pkg::GPIO_KIND_IO) begin
            emit              = 1'b1;
            rec_c.record_kind = acpi_rtp_pkg::KIND_GPIO_IO;
            rec_c.io_limit    = type_flags_next[1:0];
          end
        end
      end
    end
  end

  assign rec_valid = fire && emit;
  assign rec       = rec_c;

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      byte_position      <= '0;
      descriptor_length  <= '0;
      descriptor_tag     <= '0;
      bus_type           <= '0;
      flags_byte         <= '0;
      type_flags         <= '0;
      speed_capture      <= '0;
      address_capture    <= '0;
      gpio_kind          <= '0;
      pad_cfg_capture    <= '0;
      pin_table_offset   <= '0;
      pin_capture        <= '0;
      pin_seen           <= 1'b0;
      i2c_found          <= 1'b0;
      interrupt_found    <= 1'b0;
      parse_done         <= 1'b0;
    end else if (fire) begin
      byte_position      <= byte_position_next;
      descriptor_length  <= descriptor_length_next;
      descriptor_tag     <= descriptor_tag_next;
      bus_type           <= bus_type_next;
      flags_byte         <= flags_byte_next;
      type_flags         <= type_flags_next;
      speed_capture      <= speed_capture_next;
      address_capture    <= address_capture_next;
      gpio_kind          <= gpio_kind_next;
      pad_cfg_capture    <= pad_cfg_capture_next;
      pin_table_offset   <= pin_table_offset_next;
      pin_capture        <= pin_capture_next;
      pin_seen           <= pin_seen_next;
      i2c_found          <= i2c_found_next;
      interrupt_found    <= interrupt_found_next;
      parse_done         <= parse_done_next;
    end
  end

endmodule

// ----- sv/acpi_rtp_outbuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpi_rtp_outbuf
// Output register with one skid entry; full means the skid entry is taken
// and no new item may be accepted.
// ----------------------------------------------------------------------------
module acpi_rtp_outbuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  acpi_rtp_pkg::record_t in_rec,
  input  logic                  out_stall,
  output logic                  out_valid,
  output acpi_rtp_pkg::record_t out_rec,
  output logic                  full
);

  logic                  skid_valid;
  acpi_rtp_pkg::record_t skid_rec;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_rec <= skid_rec;
      end else if (in_valid) begin
        out_rec <= in_rec;
      end
    end else if (in_valid) begin
      skid_rec <= in_rec;
    end
  end

endmodule

// ----- sv/acpi_resource_template_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpi_resource_template_parser
// A record is registered into the output register, or into the skid entry while
// record_stall holds it; one template byte per cycle is taken while data_stall is low.
// The output register plus one skid entry let bytes flow while a record waits.
// Reset clears walker and output buffer; parser state also clears after the
// byte marked last_byte.
// ----------------------------------------------------------------------------
module acpi_resource_template_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        record_valid,
  input  logic        record_stall,
  output logic [1:0]  record_kind,
  output logic        consumer,
  output logic        dev_init,
  output logic        ten_bit_address,
  output logic [31:0] link_hz,
  output logic [15:0] target,
  output logic [2:0]  trigger_type,
  output logic [1:0]  polarity,
  output logic        shared,
  output logic        wake,
  output logic [1:0]  io_limit,
  output logic [7:0]  pad_cfg
);

  logic                  fire;
  logic                  rec_valid;
  logic                  full;
  acpi_rtp_pkg::record_t rec;
  acpi_rtp_pkg::record_t out_rec;

  assign data_stall = full;
  assign fire       = data_valid && !full;

  acpi_rtp_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  acpi_rtp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rec_valid),
    .in_rec    (rec),
    .out_stall (record_stall),
    .out_valid (record_valid),
    .out_rec   (out_rec),
    .full      (full)
  );

  assign record_kind     = out_rec.record_kind;
  assign consumer        = out_rec.consumer;
  assign dev_init        = out_rec.dev_init;
  assign ten_bit_address = out_rec.ten_bit_address;
  assign link_hz         = out_rec.link_hz;
  assign target          = out_rec.target;
  assign trigger_type    = out_rec.trigger_type;
  assign polarity        = out_rec.polarity;
  assign shared          = out_rec.shared;
  assign wake            = out_rec.wake;
  assign io_limit        = out_rec.io_limit;
  assign pad_cfg         = out_rec.pad_cfg;

endmodule
